[sv/rfc_pkg.sv]
`timescale 1ns / 1ps

package rfc_pkg;

    localparam int RFC_MAX_LEN    = 64;
    localparam int RFC_BYTE_W     = 8;
    localparam int RFC_RAILS_W    = 5;
    localparam int RFC_CFG_IDX_W  = 1;
    localparam int RFC_CFG_DATA_W = 5;

    localparam logic [RFC_RAILS_W-1:0]   RFC_RAILS_RESET = 5'd6;
    localparam logic [RFC_CFG_IDX_W-1:0] RFC_REG_RAILS   = 1'd0;
    localparam logic [RFC_CFG_IDX_W-1:0] RFC_REG_MODE    = 1'd1;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic gen_init;
        logic gen_adv;
        logic scat;
        logic rd;
        logic done;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic mode;
        logic gen_last;
    } t_sts;

endpackage

[sv/rfc_ctrl.sv]
`timescale 1ns / 1ps

module rfc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    input  logic          i_out_ready,
    input  rfc_pkg::t_sts i_sts,
    output rfc_pkg::t_cmd o_cmd,
    output logic          o_in_ready,
    output logic          o_out_valid
);
    import rfc_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAT,
        ST_DRAIN,
        ST_READ,
        ST_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   r_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_in_valid && r_in_ready) begin
                    cmd.accept = 1'b1;
                    if (i_in_last) begin
                        cmd.gen_init = 1'b1;
                        n_state      = i_sts.mode ? ST_SCAT : ST_READ;
                    end
                end
            end
            ST_SCAT: begin
                cmd.scat = 1'b1;
                if (i_sts.gen_last) begin
                    cmd.gen_init = 1'b1;
                    n_state      = ST_DRAIN;
                end else begin
                    cmd.gen_adv = 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_READ;
            end
            ST_READ: begin
                cmd.rd  = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready && r_out_valid) begin
                    if (i_sts.gen_last) begin
                        cmd.done = 1'b1;
                        n_state  = ST_LOAD;
                    end else begin
                        cmd.gen_adv = 1'b1;
                        n_state     = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= (n_state == ST_LOAD);
            r_out_valid <= (n_state == ST_OUT);
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

[sv/rfc_dp.sv]
`timescale 1ns / 1ps

module rfc_dp #(
    parameter int MAX_LEN = rfc_pkg::RFC_MAX_LEN
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rfc_pkg::RFC_CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rfc_pkg::RFC_CFG_DATA_W-1:0]  i_cfg_data,
    input  rfc_pkg::t_cmd                       i_cmd,
    input  logic [rfc_pkg::RFC_BYTE_W-1:0]      i_in_byte,
    output rfc_pkg::t_sts                       o_sts,
    output logic [rfc_pkg::RFC_BYTE_W-1:0]      o_out_byte,
    output logic                                o_out_last,
    output logic                                o_overflow
);
    import rfc_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    // position plus the widest rail step (twice the largest rail index)
    localparam int SW = RFC_RAILS_W + 1;
    localparam int PW = ((CW > SW) ? CW : SW) + 1;

    logic [RFC_BYTE_W-1:0] msg_mem  [MAX_LEN];
    logic [RFC_BYTE_W-1:0] scat_mem [MAX_LEN];

    logic [RFC_RAILS_W-1:0] r_rails;
    logic                   r_mode;
    logic [CW-1:0]          r_count;
    logic                   r_ovf;

    logic [RFC_RAILS_W-1:0] r_rail;
    logic [PW-1:0]          r_pos;
    logic                   r_phase;
    logic [CW-1:0]          r_k;

    logic                   r_scat_v;
    logic [AW-1:0]          r_scat_pos;
    logic [RFC_BYTE_W-1:0]  r_msg_q;
    logic [RFC_BYTE_W-1:0]  r_scat_q;

    logic [SW-1:0] down;
    logic [SW-1:0] up;
    logic [SW-1:0] step;
    logic [PW-1:0] nxt_pos;
    logic          pos_in;
    logic          room;
    logic [AW-1:0] msg_addr;

    // rail step selection
    always_comb begin
        down = {(r_rails - 5'd1 - r_rail), 1'b0};
        up   = {r_rail, 1'b0};
        if (r_rails < 5'd2) begin
            step = SW'(1);
        end else if (down == '0) begin
            step = up;
        end else if (up == '0) begin
            step = down;
        end else begin
            step = r_phase ? up : down;
        end
        nxt_pos = r_pos + PW'(step);
        pos_in  = (nxt_pos < PW'(r_count));
    end

    assign room     = (r_count < CW'(MAX_LEN));
    assign msg_addr = i_cmd.scat ? r_k[AW-1:0] : r_pos[AW-1:0];

    // configuration and message bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rails <= RFC_RAILS_RESET;
            r_mode  <= 1'b0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    RFC_REG_RAILS: r_rails <= i_cfg_data;
                    RFC_REG_MODE:  r_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.done) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.accept) begin
                if (room) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    // visiting order generator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rail  <= '0;
            r_pos   <= '0;
            r_phase <= 1'b0;
            r_k     <= '0;
        end else if (i_cmd.gen_init) begin
            r_rail  <= '0;
            r_pos   <= '0;
            r_phase <= 1'b0;
            r_k     <= '0;
        end else if (i_cmd.gen_adv) begin
            r_k <= r_k + CW'(1);
            if (pos_in) begin
                r_pos   <= nxt_pos;
                r_phase <= ~r_phase;
            end else begin
                r_rail  <= r_rail + 5'd1;
                r_pos   <= PW'(r_rail) + PW'(1);
                r_phase <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scat_v <= 1'b0;
        end else begin
            r_scat_v <= i_cmd.scat;
        end
    end

    // message store
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && room) begin
            msg_mem[r_count[AW-1:0]] <= i_in_byte;
        end
        if (i_cmd.scat || i_cmd.rd) begin
            r_msg_q <= msg_mem[msg_addr];
        end
        r_scat_pos <= r_pos[AW-1:0];
    end

    // scatter store
    always_ff @(posedge i_clk) begin
        if (r_scat_v) begin
            scat_mem[r_scat_pos] <= r_msg_q;
        end
        if (i_cmd.rd) begin
            r_scat_q <= scat_mem[r_k[AW-1:0]];
        end
    end

    assign o_sts.mode     = r_mode;
    assign o_sts.gen_last = ((r_k + CW'(1)) == r_count);
    assign o_out_byte     = r_mode ? r_scat_q : r_msg_q;
    assign o_out_last     = o_sts.gen_last;
    assign o_overflow     = r_ovf;

endmodule

[sv/rail_fence_cipher_unit.sv]
// channel   direction  handshake                  payload
// cfg       in         i_cfg_we                   i_cfg_idx, i_cfg_data
// in        in         i_in_valid / o_in_ready    i_in_byte, i_in_last
// out       out        o_out_valid / i_out_ready  o_out_byte, o_out_last, o_overflow
//
// loading takes one cycle per byte; input is held off from the last byte until
// the last result transaction completes
// encipher reads each byte from the message store in a read state and offers it in an output state; the
// order generator steps when a byte is taken. decipher first scatters the n bytes, then drains, then emits alike
// reset is synchronous, active low; rails resets to 6, encipher mode
// a stalled output holds its byte until taken
`timescale 1ns / 1ps

module rail_fence_cipher_unit #(
    parameter int MAX_LEN = rfc_pkg::RFC_MAX_LEN
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rfc_pkg::RFC_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rfc_pkg::RFC_CFG_DATA_W-1:0] i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [rfc_pkg::RFC_BYTE_W-1:0]     i_in_byte,
    input  logic                               i_in_last,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [rfc_pkg::RFC_BYTE_W-1:0]     o_out_byte,
    output logic                               o_out_last,
    output logic                               o_overflow
);
    import rfc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_last),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    rfc_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .i_in_byte  (i_in_byte),
        .o_sts      (sts),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last),
        .o_overflow (o_overflow)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output open together");

    a_last_in_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_last) |=> !o_in_ready)
        else $error("input still open after last byte");

    a_last_out_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_last) |=> (o_in_ready && !o_out_valid))
        else $error("input not reopened after last result");

endmodule
